>>> hw/rtl/rv32_pkg.sv
// Shared types, opcodes and status codes for the RV32I executor.
// No dependencies.
package rv32_pkg;

	localparam int MemBytesDefault = 65536;

	localparam logic [6:0] OpReg    = 7'h33;
	localparam logic [6:0] OpImm    = 7'h13;
	localparam logic [6:0] OpLui    = 7'h37;
	localparam logic [6:0] OpAuipc  = 7'h17;
	localparam logic [6:0] OpLoad   = 7'h03;
	localparam logic [6:0] OpStore  = 7'h23;
	localparam logic [6:0] OpBranch = 7'h63;
	localparam logic [6:0] OpJal    = 7'h6F;
	localparam logic [6:0] OpJalr   = 7'h67;
	localparam logic [6:0] OpSystem = 7'h73;
	localparam logic [6:0] F7Alt    = 7'h20;
	localparam logic [31:0] EcallWord = 32'h0000_0073;
	localparam logic [31:0] UpperMask = 32'hFFFF_F000;
	localparam logic [31:0] SignBit   = 32'h8000_0000;
	localparam logic [31:0] HaltCode  = 32'd10;

	// funct3 codes
	localparam logic [2:0] F3Add = 3'd0, F3Sll = 3'd1, F3Slt = 3'd2, F3Sltu = 3'd3;
	localparam logic [2:0] F3Xor = 3'd4, F3Sr = 3'd5, F3Or = 3'd6, F3And = 3'd7;
	localparam logic [2:0] F3Byte = 3'd0, F3Half = 3'd1, F3Word = 3'd2;
	localparam logic [2:0] F3ByteU = 3'd4, F3HalfU = 3'd5;
	localparam logic [2:0] F3Eq = 3'd0, F3Ne = 3'd1, F3Lt = 3'd4, F3Ge = 3'd5;
	localparam logic [2:0] F3Ltu = 3'd6, F3Geu = 3'd7;
	localparam logic [2:0] F3Jalr = 3'd0;

	// registers checked by ecall
	localparam logic [4:0] RegA0 = 5'd10;
	localparam logic [4:0] RegA7 = 5'd17;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_HALT    = 2'd1,
		ST_ILLEGAL = 2'd2,
		ST_MISALIGN = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_FETCH,
		PH_DECODE,
		PH_EXEC,
		PH_LOAD,
		PH_DUMP
	} phase_t;

	typedef struct packed {
		logic [31:0] pc_now;
		logic [1:0]  status;
		logic [4:0]  reg_index;
		logic [31:0] reg_value;
		logic        last;
	} result_t;

	typedef struct packed {
		logic        cmd;
		logic [15:0] load_addr;
		logic [31:0] load_word;
	} item_t;

	function automatic logic [31:0] alu(input logic [2:0] f3, input logic alt,
			input logic [31:0] a, input logic [31:0] b);
		logic [31:0] r;
		case (f3)
			F3Add: r = alt ? a - b : a + b;
			F3Sll: r = a << b[4:0];
			F3Slt: r = {31'd0, $signed(a) < $signed(b)};
			F3Sltu: r = {31'd0, a < b};
			F3Xor: r = a ^ b;
			F3Sr: r = alt ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
			F3Or: r = a | b;
			default: r = a & b;
		endcase
		return r;
	endfunction

endpackage

>>> hw/rtl/rv32_stream_if.sv
// Valid/ready channel carrying one payload of type T.
// Depends on nothing; payload types come from rv32_pkg.
interface rv32_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/rv32_ram.sv
// Generic single-port RAM with a registered read.
// No dependencies.
module rv32_ram #(
	parameter int Width = 8,
	parameter int Depth = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

>>> hw/rtl/rv32i_instruction_executor.sv
// RV32I executor top level: sequencer, register file and byte memory.
// Depends on rv32_pkg, rv32_stream_if and rv32_ram.
//
// A write item goes via EXEC, a step via FETCH, DECODE, EXEC (and LOAD for
// a load; memory and register reads are registered), and a halting ecall
// emits 32 results, one per cycle while the output has room. The byte memory
// is four byte-lane RAMs of MEM_BYTES/4 rows each; an unaligned word access
// addresses each lane at its own row, so it needs no second access. The next
// item is taken while the result waits in the output register. No clearing
// pass is needed: the register file is flops that reset to zero.
module rv32i_instruction_executor #(
	parameter int MEM_BYTES = rv32_pkg::MemBytesDefault
) (
	input  logic clk,
	input  logic arst_n,
	rv32_stream_if.sink   in_ch,
	rv32_stream_if.source out_ch
);
	localparam int AW = $clog2(MEM_BYTES);
	localparam int RW = AW - 2;
	localparam int Rows = MEM_BYTES / 4;

	rv32_pkg::phase_t ph_q, ph_d;
	logic [31:0] pc_q, pc_d;
	logic [1:0]  run_q, run_d;
	logic [31:0] regs_q [32];
	logic [31:0] instr_q, a_q, b_q;
	logic [4:0]  rd_q, dump_q;
	logic        cmd_q;

	logic out_full_q;
	rv32_pkg::result_t res_q;
	logic push;
	rv32_pkg::result_t push_res;

	// byte-lane memory
	logic [3:0] lane_we;
	logic [RW-1:0] lane_addr [4];
	logic [7:0] lane_wd [4], lane_rd [4];
	logic [1:0] rot_q;

	for (genvar g = 0; g < 4; g++) begin : g_lane
		rv32_ram #(.Width(8), .Depth(Rows)) u_ram (
			.clk, .we(lane_we[g]), .addr(lane_addr[g]),
			.wdata(lane_wd[g]), .rdata(lane_rd[g]));
	end

	// Word read with address a: byte k at a+k lives in lane (a+k)%4,
	// row ((a+k)%MEM)/4. Rotate back by a[1:0] after the read.
	function automatic logic [RW-1:0] row_of(input logic [31:0] a, input int k);
		logic [31:0] s;
		s = a + 32'(k);
		return s[AW-1:2];
	endfunction

	logic [31:0] rd_word;
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			rd_word[8*k +: 8] = lane_rd[2'(rot_q + 2'(k))];
		end
	end

	logic can_push;
	assign can_push = !out_full_q || out_ch.ready;

	// decode fields
	logic [6:0] op, f7;
	logic [2:0] f3;
	logic [31:0] immi, imms, immb, immj;
	assign op = instr_q[6:0];
	assign f3 = instr_q[14:12];
	assign f7 = instr_q[31:25];
	assign immi = {{20{instr_q[31]}}, instr_q[31:20]};
	assign imms = {{20{instr_q[31]}}, instr_q[31:25], instr_q[11:7]};
	assign immb = {{19{instr_q[31]}}, instr_q[31], instr_q[7], instr_q[30:25],
		instr_q[11:8], 1'b0};
	assign immj = {{11{instr_q[31]}}, instr_q[31], instr_q[19:12], instr_q[20],
		instr_q[30:21], 1'b0};

	logic [3:0] bmask;
	logic [31:0] sdata;
	always_comb begin
		case (f3)
			rv32_pkg::F3Byte: bmask = 4'b0001;
			rv32_pkg::F3Half: bmask = 4'b0011;
			default: bmask = 4'b1111;
		endcase
	end

	// register update request
	logic reg_we;
	logic [4:0] reg_wa;
	logic [31:0] reg_wd;
	logic [31:0] ex_val;
	logic ex_ok, ex_wr, ex_halt, take;
	logic [31:0] ex_next;
	logic [31:0] load_val;

	always_comb begin
		ex_ok = 1'b1; ex_wr = 1'b0; ex_halt = 1'b0; ex_val = '0;
		ex_next = pc_q + 32'd4; take = 1'b0;
		case (op)
			rv32_pkg::OpReg: begin
				if (f7 == '0 || (f7 == rv32_pkg::F7Alt
						&& (f3 == rv32_pkg::F3Add || f3 == rv32_pkg::F3Sr))) begin
					ex_val = rv32_pkg::alu(f3, f7 == rv32_pkg::F7Alt, a_q, b_q);
					ex_wr = 1'b1;
				end else ex_ok = 1'b0;
			end
			rv32_pkg::OpImm: begin
				if (f3 == rv32_pkg::F3Sll && f7 != '0) ex_ok = 1'b0;
				else if (f3 == rv32_pkg::F3Sr && f7 != '0 && f7 != rv32_pkg::F7Alt)
					ex_ok = 1'b0;
				else begin
					ex_val = rv32_pkg::alu(f3, f3 == rv32_pkg::F3Sr && f7 == rv32_pkg::F7Alt,
						a_q, immi);
					ex_wr = 1'b1;
				end
			end
			rv32_pkg::OpLui: begin
				ex_val = instr_q & rv32_pkg::UpperMask; ex_wr = 1'b1;
			end
			rv32_pkg::OpAuipc: begin
				ex_val = pc_q + (instr_q & rv32_pkg::UpperMask); ex_wr = 1'b1;
			end
			rv32_pkg::OpLoad: begin
				if (f3 inside {rv32_pkg::F3Byte, rv32_pkg::F3Half, rv32_pkg::F3Word,
						rv32_pkg::F3ByteU, rv32_pkg::F3HalfU}) ex_wr = 1'b1;
				else ex_ok = 1'b0;
			end
			rv32_pkg::OpStore: begin
				if (f3 > rv32_pkg::F3Word) ex_ok = 1'b0;
			end
			rv32_pkg::OpBranch: begin
				case (f3)
					rv32_pkg::F3Eq: take = a_q == b_q;
					rv32_pkg::F3Ne: take = a_q != b_q;
					rv32_pkg::F3Lt: take = $signed(a_q) < $signed(b_q);
					rv32_pkg::F3Ge: take = $signed(a_q) >= $signed(b_q);
					rv32_pkg::F3Ltu: take = a_q < b_q;
					rv32_pkg::F3Geu: take = a_q >= b_q;
					default: ex_ok = 1'b0;
				endcase
				if (take) ex_next = pc_q + immb;
			end
			rv32_pkg::OpJal: begin
				ex_val = pc_q + 32'd4; ex_wr = 1'b1; ex_next = pc_q + immj;
			end
			rv32_pkg::OpJalr: begin
				if (f3 == rv32_pkg::F3Jalr) begin
					ex_val = pc_q + 32'd4; ex_wr = 1'b1;
					ex_next = (a_q + immi) & ~32'd1;
				end else ex_ok = 1'b0;
			end
			rv32_pkg::OpSystem: begin
				if (instr_q == rv32_pkg::EcallWord) begin
					ex_halt = regs_q[rv32_pkg::RegA7] == rv32_pkg::HaltCode
						|| regs_q[rv32_pkg::RegA0] == rv32_pkg::HaltCode;
				end else ex_ok = 1'b0;
			end
			default: ex_ok = 1'b0;
		endcase
	end

	always_comb begin
		case (f3)
			rv32_pkg::F3Byte: load_val = {{24{rd_word[7]}}, rd_word[7:0]};
			rv32_pkg::F3Half: load_val = {{16{rd_word[15]}}, rd_word[15:0]};
			rv32_pkg::F3ByteU: load_val = {24'd0, rd_word[7:0]};
			rv32_pkg::F3HalfU: load_val = {16'd0, rd_word[15:0]};
			default: load_val = rd_word;
		endcase
	end

	logic [31:0] mem_a;
	logic [31:0] mem_d;
	logic [3:0]  mem_bm;
	logic        mem_wr;
	logic [1:0]  rot_d;

	always_comb begin
		ph_d = ph_q; pc_d = pc_q; run_d = run_q;
		push = 1'b0; push_res = '0;
		reg_we = 1'b0; reg_wa = '0; reg_wd = '0;
		mem_a = '0; mem_d = '0; mem_bm = '0; mem_wr = 1'b0; rot_d = rot_q;
		in_ch.ready = 1'b0;
		sdata = b_q;
		case (ph_q)
			rv32_pkg::PH_IDLE: begin
				in_ch.ready = 1'b1;
				if (in_ch.valid) begin
					if (!in_ch.data.cmd) begin
						mem_a = 32'(in_ch.data.load_addr); mem_d = in_ch.data.load_word;
						mem_bm = 4'hF; mem_wr = 1'b1;
						ph_d = rv32_pkg::PH_EXEC;
					end else if (run_q != rv32_pkg::ST_OK) begin
						ph_d = rv32_pkg::PH_EXEC;
					end else begin
						mem_a = pc_q; rot_d = pc_q[1:0];
						ph_d = rv32_pkg::PH_FETCH;
					end
				end
			end
			rv32_pkg::PH_FETCH: ph_d = rv32_pkg::PH_DECODE;
			rv32_pkg::PH_DECODE: ph_d = rv32_pkg::PH_EXEC;
			rv32_pkg::PH_EXEC: begin
				if (can_push) begin
					push = 1'b1; ph_d = rv32_pkg::PH_IDLE;
					push_res.pc_now = pc_q; push_res.status = run_q;
					push_res.last = 1'b1;
					if (cmd_q && run_q == rv32_pkg::ST_OK) begin
						if (!ex_ok) begin
							run_d = rv32_pkg::ST_ILLEGAL;
							push_res.status = rv32_pkg::ST_ILLEGAL;
						end else if (op == rv32_pkg::OpLoad) begin
							push = 1'b0; mem_a = a_q + immi; rot_d = mem_a[1:0];
							ph_d = rv32_pkg::PH_LOAD;
						end else begin
							if (op == rv32_pkg::OpStore) begin
								mem_a = a_q + imms; mem_d = sdata; mem_bm = bmask;
								mem_wr = 1'b1;
							end
							pc_d = ex_next;
							push_res.pc_now = ex_next;
							if (ex_wr && rd_q != '0) begin
								reg_we = 1'b1; reg_wa = rd_q; reg_wd = ex_val;
								push_res.reg_index = rd_q; push_res.reg_value = ex_val;
							end
							if (ex_halt) begin
								push = 1'b0; run_d = rv32_pkg::ST_HALT;
								ph_d = rv32_pkg::PH_DUMP;
							end else if (ex_next[1:0] != 2'd0) begin
								run_d = rv32_pkg::ST_MISALIGN;
								push_res.status = rv32_pkg::ST_MISALIGN;
							end
						end
					end
				end
			end
			rv32_pkg::PH_LOAD: begin
				if (can_push) begin
					push = 1'b1; ph_d = rv32_pkg::PH_IDLE;
					pc_d = ex_next; push_res.pc_now = ex_next; push_res.last = 1'b1;
					push_res.status = run_q;
					if (rd_q != '0) begin
						reg_we = 1'b1; reg_wa = rd_q; reg_wd = load_val;
						push_res.reg_index = rd_q; push_res.reg_value = load_val;
					end
					if (ex_next[1:0] != 2'd0) begin
						run_d = rv32_pkg::ST_MISALIGN;
						push_res.status = rv32_pkg::ST_MISALIGN;
					end
				end
			end
			rv32_pkg::PH_DUMP: begin
				if (can_push) begin
					push = 1'b1;
					push_res.pc_now = pc_q; push_res.status = run_q;
					push_res.reg_index = dump_q;
					push_res.reg_value = (dump_q == '0) ? '0 : regs_q[dump_q];
					push_res.last = dump_q == 5'd31;
					if (dump_q == 5'd31) ph_d = rv32_pkg::PH_IDLE;
				end
			end
			default: ph_d = rv32_pkg::PH_IDLE;
		endcase
	end

	// map a byte-addressed word access onto the four lanes
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			logic [1:0] ln;
			ln = 2'(mem_a[1:0] + 2'(k));
			lane_addr[ln] = row_of(mem_a, k);
			lane_wd[ln] = mem_d[8*k +: 8];
			lane_we[ln] = mem_wr && mem_bm[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= rv32_pkg::PH_IDLE;
			pc_q <= '0;
			run_q <= rv32_pkg::ST_OK;
			out_full_q <= 1'b0;
			dump_q <= '0;
			for (int i = 0; i < 32; i++) regs_q[i] <= '0;
		end else begin
			ph_q <= ph_d;
			pc_q <= pc_d;
			run_q <= run_d;
			if (push) out_full_q <= 1'b1;
			else if (out_ch.ready) out_full_q <= 1'b0;
			if (reg_we) regs_q[reg_wa] <= reg_wd;
			if (ph_q == rv32_pkg::PH_DUMP && can_push) dump_q <= dump_q + 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		rot_q <= rot_d;
		if (push) res_q <= push_res;
		if (in_ch.valid && in_ch.ready) cmd_q <= in_ch.data.cmd;
		if (ph_q == rv32_pkg::PH_FETCH) begin
			instr_q <= rd_word;
			rd_q <= rd_word[11:7];
			a_q <= (rd_word[19:15] == '0) ? '0 : regs_q[rd_word[19:15]];
			b_q <= (rd_word[24:20] == '0) ? '0 : regs_q[rd_word[24:20]];
		end
	end

	assign out_ch.valid = out_full_q;
	assign out_ch.data = res_q;

	a_halt_dump: assert property (@(posedge clk) disable iff (!arst_n)
		ph_q == rv32_pkg::PH_DUMP |-> run_q == rv32_pkg::ST_HALT)
		else $error("dump outside halt");
	a_x0_zero: assert property (@(posedge clk) disable iff (!arst_n)
		regs_q[0] == '0) else $error("x0 written");
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> ph_q == rv32_pkg::PH_IDLE) else $error("accept while busy");
endmodule
